// ----- src/mm_pkg.sv -----
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants for the matrix multiply block
// Word formats, request and register codes, and chain control structs.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int DIM_W          = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int OUT_W          = 32;

  typedef enum logic [1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              out_row;
    logic [2:0]              out_col;
    logic signed [OUT_W-1:0] out_value;
    logic                    last;
  } out_word_t;

  // operand stream handed from cell to cell
  typedef struct packed {
    logic vld;
    logic first;
  } cell_ctl_t;

  // result lane control, broadcast to all cells
  typedef struct packed {
    logic load;
    logic shift;
    logic zero;
  } lane_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] lim);
    return (d > lim) ? lim : d;
  endfunction

endpackage

// ----- src/matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply: dense fixed-point matrix multiply R = A * B
// Load words fill A and B; a compute word emits R in row-major order.
// ----------------------------------------------------------------------------
// For each result row of a compute word the sequencer reads one A element
// per cycle from the A memory, the element walks the chain of MAX_DIM
// column cells (each holding one column of B and one multiplier), then the
// row of results is shifted out of the chain head one word per cycle while
// the output is not stalled. Inputs are not taken while a compute word is
// in progress.
module matrix_multiply #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mm_pkg::in_word_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mm_pkg::out_word_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mm_pkg::DIM_W-1:0]      cfg_data_i
);

  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int AADDR_W   = 2 * IDX_W;
  localparam int DRAIN_W   = $clog2(MAX_DIM + 3);
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(MAX_DIM + 2);
  localparam logic [mm_pkg::DIM_W-1:0] DIM_MAX = mm_pkg::DIM_W'(MAX_DIM);
  localparam logic [mm_pkg::DIM_W-1:0] ONE     = mm_pkg::DIM_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                     state_d, state_q;
  logic [mm_pkg::DIM_W-1:0]   rows_q, inner_q, cols_q;
  logic [mm_pkg::DIM_W-1:0]   m_d, m_q, n_d, n_q, o_d, o_q;
  logic [mm_pkg::DIM_W-1:0]   i_d, i_q, k_d, k_q, j_d, j_q;
  logic [DRAIN_W-1:0]         drain_d, drain_q;
  logic                       a_vld_q, a_first_q;
  logic [IDX_W-1:0]           a_k_q;
  logic                       out_vld_d, out_vld_q;
  mm_pkg::out_word_t          out_d, out_q;

  logic                       in_acc, wr_ok, issue, emit_move;
  logic [mm_pkg::DIM_W-1:0]   m_c, n_c, o_c;
  logic signed [ELEM_WIDTH-1:0] elem;
  logic [ELEM_WIDTH-1:0]      a_rdata;
  mm_pkg::lane_ctl_t          lane_ctl;

  logic signed [ELEM_WIDTH-1:0]    a_ch   [MAX_DIM+1];
  logic [IDX_W-1:0]                k_ch   [MAX_DIM+1];
  mm_pkg::cell_ctl_t               ctl_ch [MAX_DIM+1];
  logic signed [mm_pkg::OUT_W-1:0] lane_ch[MAX_DIM];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign elem        = ELEM_WIDTH'(in_data_i.element_value);
  assign wr_ok       = ({1'b0, in_data_i.row_index} < DIM_MAX) &&
                       ({1'b0, in_data_i.col_index} < DIM_MAX);
  assign m_c         = mm_pkg::clamp_dim(rows_q, DIM_MAX);
  assign n_c         = mm_pkg::clamp_dim(inner_q, DIM_MAX);
  assign o_c         = mm_pkg::clamp_dim(cols_q, DIM_MAX);
  assign issue       = (state_q == ST_ISSUE);
  assign emit_move   = (state_q == ST_EMIT) && (!out_vld_q || out_ready_i);

  assign lane_ctl.load  = (state_q == ST_DRAIN) && (drain_q == DRAIN_LAST);
  assign lane_ctl.shift = emit_move;
  assign lane_ctl.zero  = (n_q == '0);

  mm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (2 ** AADDR_W)
  ) u_a_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_data_i.req_type == mm_pkg::REQ_WRITE_A) && wr_ok),
    .waddr_i ({in_data_i.row_index[IDX_W-1:0], in_data_i.col_index[IDX_W-1:0]}),
    .wdata_i (elem),
    .raddr_i ({i_q[IDX_W-1:0], k_q[IDX_W-1:0]}),
    .rdata_o (a_rdata)
  );

  assign a_ch[0]   = $signed(a_rdata);
  assign k_ch[0]   = a_k_q;
  assign ctl_ch[0] = '{vld: a_vld_q, first: a_first_q};

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    logic signed [mm_pkg::OUT_W-1:0] lane_next;
    if (g < MAX_DIM - 1) begin : g_mid
      assign lane_next = lane_ch[g+1];
    end else begin : g_end
      assign lane_next = '0;
    end

    mm_cell #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .a_i        (a_ch[g]),
      .k_i        (k_ch[g]),
      .ctl_i      (ctl_ch[g]),
      .a_o        (a_ch[g+1]),
      .k_o        (k_ch[g+1]),
      .ctl_o      (ctl_ch[g+1]),
      .b_we_i     (in_acc && (in_data_i.req_type == mm_pkg::REQ_WRITE_B) && wr_ok &&
                   (in_data_i.col_index[IDX_W-1:0] == IDX_W'(g))),
      .b_waddr_i  (in_data_i.row_index[IDX_W-1:0]),
      .b_wdata_i  (elem),
      .lane_ctl_i (lane_ctl),
      .lane_i     (lane_next),
      .lane_o     (lane_ch[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    m_d       = m_q;
    n_d       = n_q;
    o_d       = o_q;
    i_d       = i_q;
    k_d       = k_q;
    j_d       = j_q;
    drain_d   = drain_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.req_type == mm_pkg::REQ_COMPUTE)) begin
          m_d     = m_c;
          n_d     = n_c;
          o_d     = o_c;
          i_d     = '0;
          k_d     = '0;
          drain_d = '0;
          if ((m_c != '0) && (o_c != '0)) begin
            state_d = (n_c == '0) ? ST_DRAIN : ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        k_d = k_q + ONE;
        if (k_q + ONE == n_q) begin
          state_d = ST_DRAIN;
          drain_d = '0;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + DRAIN_W'(1);
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_EMIT;
          j_d     = '0;
        end
      end
      ST_EMIT: begin
        if (emit_move) begin
          out_vld_d         = 1'b1;
          out_d.out_row     = i_q[2:0];
          out_d.out_col     = j_q[2:0];
          out_d.out_value   = lane_ch[0];
          out_d.last        = (i_q + ONE == m_q) && (j_q + ONE == o_q);
          j_d               = j_q + ONE;
          if (j_q + ONE == o_q) begin
            k_d     = '0;
            drain_d = '0;
            if (i_q + ONE == m_q) begin
              state_d = ST_IDLE;
            end else begin
              i_d     = i_q + ONE;
              state_d = (n_q == '0) ? ST_DRAIN : ST_ISSUE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rows_q    <= mm_pkg::DIM_W'(3);
      inner_q   <= mm_pkg::DIM_W'(3);
      cols_q    <= mm_pkg::DIM_W'(3);
      m_q       <= '0;
      n_q       <= '0;
      o_q       <= '0;
      i_q       <= '0;
      k_q       <= '0;
      j_q       <= '0;
      drain_q   <= '0;
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_q       <= m_d;
      n_q       <= n_d;
      o_q       <= o_d;
      i_q       <= i_d;
      k_q       <= k_d;
      j_q       <= j_d;
      drain_q   <= drain_d;
      a_vld_q   <= issue;
      a_first_q <= (k_q == '0);
      a_k_q     <= k_q[IDX_W-1:0];
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mm_pkg::CFG_ROWS_A:    rows_q  <= cfg_data_i;
          mm_pkg::CFG_INNER_DIM: inner_q <= cfg_data_i;
          mm_pkg::CFG_COLS_B:    cols_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (j_q < o_q) && (i_q < m_q))
    else $error("emit counters out of range");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (k_q < n_q) && (n_q != '0))
    else $error("issue counter out of range");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.req_type == mm_pkg::REQ_COMPUTE) &&
     (m_c != '0) && (o_c != '0)) |=> (state_q != ST_IDLE))
    else $error("compute word did not start");

  a_last_ends_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_move && (i_q + ONE == m_q) && (j_q + ONE == o_q)) |=>
      (state_q == ST_IDLE) && out_vld_q && out_q.last)
    else $error("final result word not marked last");
`endif

endmodule

// ----- src/mm_ram.sv -----
// ----------------------------------------------------------------------------
// mm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mm_cell.sv -----
// ----------------------------------------------------------------------------
// mm_cell: one column cell of the multiply chain
// Holds one column of B, multiplies the passing A element by its B element,
// accumulates one result and shifts finished results toward the chain head.
// ----------------------------------------------------------------------------
module mm_cell #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [ELEM_WIDTH-1:0]       a_i,
  input  logic [$clog2(MAX_DIM)-1:0]         k_i,
  input  mm_pkg::cell_ctl_t                  ctl_i,
  output logic signed [ELEM_WIDTH-1:0]       a_o,
  output logic [$clog2(MAX_DIM)-1:0]         k_o,
  output mm_pkg::cell_ctl_t                  ctl_o,
  input  logic                               b_we_i,
  input  logic [$clog2(MAX_DIM)-1:0]         b_waddr_i,
  input  logic signed [ELEM_WIDTH-1:0]       b_wdata_i,
  input  mm_pkg::lane_ctl_t                  lane_ctl_i,
  input  logic signed [mm_pkg::OUT_W-1:0]    lane_i,
  output logic signed [mm_pkg::OUT_W-1:0]    lane_o
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + IDX_W + 1;
  localparam int SAT_W  = (ACC_W > mm_pkg::OUT_W + 1) ? ACC_W : mm_pkg::OUT_W + 1;
  localparam logic signed [SAT_W-1:0] POS_LIM = SAT_W'(32'sh7fff_ffff);
  localparam logic signed [SAT_W-1:0] NEG_LIM = SAT_W'(32'sh8000_0000);

  logic signed [ELEM_WIDTH-1:0]    a_q;
  logic [IDX_W-1:0]                k_q;
  mm_pkg::cell_ctl_t               ctl_q;
  logic [ELEM_WIDTH-1:0]           b_rdata;
  logic signed [PROD_W-1:0]        prod_d, prod_q;
  mm_pkg::cell_ctl_t               pctl_q;
  logic signed [ACC_W-1:0]         acc_d, acc_q;
  logic signed [SAT_W-1:0]         acc_ext;
  logic signed [mm_pkg::OUT_W-1:0] sat_val;
  logic signed [mm_pkg::OUT_W-1:0] lane_d, lane_q;

  mm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (2 ** IDX_W)
  ) u_b_col (
    .clk_i   (clk_i),
    .we_i    (b_we_i),
    .waddr_i (b_waddr_i),
    .wdata_i (b_wdata_i),
    .raddr_i (k_i),
    .rdata_o (b_rdata)
  );

  always_comb begin
    prod_d  = a_q * $signed(b_rdata);
    acc_d   = pctl_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    acc_ext = SAT_W'(acc_q);
    if (acc_ext > POS_LIM) begin
      sat_val = 32'sh7fff_ffff;
    end else if (acc_ext < NEG_LIM) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = mm_pkg::OUT_W'(acc_ext);
    end
    lane_d = lane_q;
    if (lane_ctl_i.load) begin
      lane_d = lane_ctl_i.zero ? '0 : sat_val;
    end else if (lane_ctl_i.shift) begin
      lane_d = lane_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      pctl_q <= '0;
    end else begin
      ctl_q  <= ctl_i;
      pctl_q <= ctl_q;
      a_q    <= a_i;
      k_q    <= k_i;
      prod_q <= prod_d;
      lane_q <= lane_d;
      if (pctl_q.vld) begin
        acc_q <= acc_d;
      end
    end
  end

  assign a_o    = a_q;
  assign k_o    = k_q;
  assign ctl_o  = ctl_q;
  assign lane_o = lane_q;

endmodule

// ----- tb/sv/product_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// product_scoreboard_pkg: expected-result tracking for matrix_multiply
// Mirrors the A and B element stores and the dimension registers, works out
// every element of A * B when a compute word is accepted, and checks the
// result words against them in order.
// ----------------------------------------------------------------------------
package product_scoreboard_pkg;

  import mm_pkg::*;

  localparam int MAX_DIM = MAX_DIM_DEF;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  class product_scoreboard;

    logic signed [15:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [15:0] b_mem [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]   dim_rows  = 4'd3;
    logic [DIM_W-1:0]   dim_inner = 4'd3;
    logic [DIM_W-1:0]   dim_cols  = 4'd3;
    out_word_t          expected_elems[$];
    int unsigned        mismatches = 0;
    int unsigned        words_seen = 0;
    int unsigned        products   = 0;
    int unsigned        elems_seen = 0;

    function int unsigned clamped(logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function int unsigned pending();
      return expected_elems.size();
    endfunction

    function void set_dim(cfg_e idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_ROWS_A:    dim_rows  = val;
        CFG_INNER_DIM: dim_inner = val;
        CFG_COLS_B:    dim_cols  = val;
        default: ;
      endcase
    endfunction

    function void note_word(in_word_t w);
      int unsigned slot;
      int unsigned m;
      int unsigned k;
      int unsigned o;
      longint      acc;
      out_word_t   elem;
      words_seen++;
      slot = w.row_index * MAX_DIM + w.col_index;
      case (w.req_type)
        REQ_WRITE_A: begin
          if (w.row_index < MAX_DIM && w.col_index < MAX_DIM) a_mem[slot] = w.element_value;
        end
        REQ_WRITE_B: begin
          if (w.row_index < MAX_DIM && w.col_index < MAX_DIM) b_mem[slot] = w.element_value;
        end
        REQ_COMPUTE: begin
          products++;
          m = clamped(dim_rows);
          k = clamped(dim_inner);
          o = clamped(dim_cols);
          for (int unsigned i = 0; i < m; i++) begin
            for (int unsigned j = 0; j < o; j++) begin
              acc = 0;
              for (int unsigned n = 0; n < k; n++) begin
                acc += longint'(a_mem[i*MAX_DIM + n]) * longint'(b_mem[n*MAX_DIM + j]);
              end
              if (acc > SAT_HI) acc = SAT_HI;
              else if (acc < SAT_LO) acc = SAT_LO;
              elem.out_row   = i[2:0];
              elem.out_col   = j[2:0];
              elem.out_value = acc[31:0];
              elem.last      = (i + 1 == m) && (j + 1 == o);
              expected_elems.push_back(elem);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_elem(out_word_t got);
      out_word_t want;
      if (expected_elems.size() == 0) begin
        $error("unexpected result word: row %0d col %0d value %0d last %0d",
               got.out_row, got.out_col, got.out_value, got.last);
        mismatches++;
        return;
      end
      want = expected_elems.pop_front();
      elems_seen++;
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        mismatches++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        mismatches++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// ----- tb/sv/matrix_multiply_tb.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_tb: self-checking bench for the matrix multiply block
// Loads A and B elements, runs products under many dimension settings
// (zero, one, full and oversize), with bursty input and a stalling result
// sink, and checks every result word against a predicted product.
// ----------------------------------------------------------------------------
module matrix_multiply_tb;

  import mm_pkg::*;
  import product_scoreboard_pkg::*;

  localparam int MAX_DIM        = MAX_DIM_DEF;
  localparam int QUIET_CYCLES   = MAX_DIM * (3 * MAX_DIM + 2) + 40;
  localparam int LONG_HOLD      = 400;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int WORD_TARGET    = 220;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i  = '0;

  product_scoreboard sb;

  bit          a_loaded [MAX_DIM*MAX_DIM];
  bit          b_loaded [MAX_DIM*MAX_DIM];
  bit          gaps_on       = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned burst_left    = 1;
  int unsigned words_sent    = 0;
  int unsigned settings_seen = 0;

  matrix_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 10);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_elem(out_data_o);
    end
  end

  // result sink: ready pattern re-picked at random, long hold on request
  initial begin : result_sink
    int unsigned rx_cycle;
    int unsigned rx_mode;
    rx_cycle = 0;
    rx_mode  = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ((rx_cycle % 5) < 2);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
        rx_cycle++;
        if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
      end
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(1, 4));
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_word(input in_word_t w);
    int unsigned slot;
    slot = w.row_index * MAX_DIM + w.col_index;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    if (w.req_type == REQ_WRITE_A) a_loaded[slot] = 1'b1;
    if (w.req_type == REQ_WRITE_B) b_loaded[slot] = 1'b1;
    if (w.req_type != REQ_NONE) words_sent++;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
    end
  endtask

  task automatic load(input req_e kind, input logic [2:0] r, input logic [2:0] c,
                      input logic [15:0] v);
    in_word_t w;
    w.req_type      = kind;
    w.row_index     = r;
    w.col_index     = c;
    w.element_value = v;
    send_word(w);
  endtask

  // loads any element the product will read that was never written
  task automatic run_product();
    int unsigned m;
    int unsigned k;
    int unsigned o;
    in_word_t    w;
    m = sb.clamped(sb.dim_rows);
    k = sb.clamped(sb.dim_inner);
    o = sb.clamped(sb.dim_cols);
    for (int unsigned r = 0; r < m; r++)
      for (int unsigned c = 0; c < k; c++)
        if (!a_loaded[r*MAX_DIM + c]) load(REQ_WRITE_A, r[2:0], c[2:0], pick_value());
    for (int unsigned r = 0; r < k; r++)
      for (int unsigned c = 0; c < o; c++)
        if (!b_loaded[r*MAX_DIM + c]) load(REQ_WRITE_B, r[2:0], c[2:0], pick_value());
    w = in_word_t'(24'($urandom));
    w.req_type = REQ_COMPUTE;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    wait_drained();
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_dim(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
                          input logic [DIM_W-1:0] o);
    write_reg(CFG_ROWS_A, m);
    write_reg(CFG_INNER_DIM, k);
    write_reg(CFG_COLS_B, o);
    settings_seen++;
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned m;
    int unsigned k;
    int unsigned o;
    int unsigned roll;
    in_word_t    w;
    m = sb.clamped(sb.dim_rows);
    k = sb.clamped(sb.dim_inner);
    o = sb.clamped(sb.dim_cols);
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        run_product();
      end else if (roll < 20) begin
        w = in_word_t'(24'($urandom));
        w.req_type = REQ_NONE;
        send_word(w);
      end else if (roll < 30) begin
        load(req_e'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), pick_value());
      end else if (roll < 33) begin
        wait_drained();
      end else if (roll < 66 && m > 0 && k > 0) begin
        load(REQ_WRITE_A, 3'($urandom_range(0, m - 1)), 3'($urandom_range(0, k - 1)),
             pick_value());
      end else if (k > 0 && o > 0) begin
        load(REQ_WRITE_B, 3'($urandom_range(0, k - 1)), 3'($urandom_range(0, o - 1)),
             pick_value());
      end else begin
        load(req_e'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), pick_value());
      end
    end
    run_product();
  endtask

  initial begin : stimulus
    in_word_t w;
    sb = new;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 1x1x1: extreme products, ignored request, store writes outside the dims
    set_dims(4'd1, 4'd1, 4'd1);
    write_reg(CFG_UNUSED, 4'hF);
    load(REQ_WRITE_A, 3'd0, 3'd0, 16'h8000);
    load(REQ_WRITE_B, 3'd0, 3'd0, 16'h8000);
    run_product();
    load(REQ_WRITE_B, 3'd0, 3'd0, 16'h7FFF);
    run_product();
    w = '{req_type: REQ_NONE, row_index: 3'd7, col_index: 3'd7, element_value: 16'hFFFF};
    send_word(w);
    load(REQ_WRITE_A, 3'd7, 3'd7, 16'h5555);
    load(REQ_WRITE_B, 3'd7, 3'd7, 16'hAAAA);
    settle();

    // positive then negative saturation
    set_dims(4'd1, 4'd3, 4'd1);
    load(REQ_WRITE_A, 3'd0, 3'd1, 16'h8000);
    load(REQ_WRITE_A, 3'd0, 3'd2, 16'h8000);
    load(REQ_WRITE_B, 3'd0, 3'd0, 16'h8000);
    load(REQ_WRITE_B, 3'd1, 3'd0, 16'h8000);
    load(REQ_WRITE_B, 3'd2, 3'd0, 16'h8000);
    run_product();
    load(REQ_WRITE_B, 3'd0, 3'd0, 16'h7FFF);
    load(REQ_WRITE_B, 3'd1, 3'd0, 16'h7FFF);
    load(REQ_WRITE_B, 3'd2, 3'd0, 16'h7FFF);
    run_product();
    settle();

    // zero dimensions: no results, an all-zero result, then no results again
    set_dims(4'd0, 4'd3, 4'd1);
    run_product();
    settle();
    set_dims(4'd1, 4'd0, 4'd1);
    run_product();
    settle();
    set_dims(4'd1, 4'd3, 4'd0);
    run_product();
    settle();

    // oversize dims clamp to full size; sink holds off while input keeps coming
    set_dims(4'd15, 4'd15, 4'd15);
    run_product();
    long_hold_req = 1'b1;
    random_phase(20);

    while (words_sent < WORD_TARGET) begin
      settle();
      set_dims(pick_dim(), pick_dim(), pick_dim());
      gaps_on = ($urandom_range(0, 3) != 0);
      random_phase($urandom_range(15, 40));
    end

    settle();
    $display("Sent %0d words (%0d products) over %0d dimension settings;", sb.words_seen,
             sb.products, settings_seen);
    $display("checked %0d result words, with zero, oversize and saturating cases.",
             sb.elems_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mm_pkg.sv
src/mm_ram.sv
src/mm_cell.sv
src/matrix_multiply.sv
tb/sv/product_scoreboard_pkg.sv
tb/sv/matrix_multiply_tb.sv
